@@ design/urss_pkg.sv @@
package urss_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int DIGIT_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int SEL_W       = 4;

    localparam int TRIG_W  = 16;
    localparam int HOLD_W  = 24;
    localparam int DTICK_W = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam int DIST_W   = 14;
    localparam int DIST_MAX = 9999;

    // distance = count * 10 / 58, tracked as a running quotient and remainder
    localparam int ECHO_NUM = 10;
    localparam int ECHO_DEN = 58;
    localparam int REM_W    = $clog2(ECHO_DEN);

    localparam logic [TRIG_W-1:0]  TRIG_RESET  = TRIG_W'(100);
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(50100);
    localparam logic [DTICK_W-1:0] DTICK_RESET = DTICK_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_TICKS   = CFG_IDX_W'(2);

    localparam logic [1:0] PH_TRIG = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_MEAS = 2'd2;
    localparam logic [1:0] PH_HOLD = 2'd3;

    typedef logic [3:0] bcd_t;
    typedef bcd_t [NUM_DIGITS-1:0] bcd_word_t;

    function automatic logic [6:0] seg_pattern(input bcd_t digit);
        logic [6:0] pattern;
        unique case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

@@ design/urss_sample_if.sv @@
interface urss_sample_if;
    logic valid;
    logic ready;
    logic echo;

    modport source (output valid, output echo, input ready);
    modport sink   (input valid, input echo, output ready);
endinterface

@@ design/urss_result_if.sv @@
interface urss_result_if;
    logic        valid;
    logic        ready;
    logic        trigger;
    logic [6:0]  segments;
    logic [3:0]  digit_select;
    logic        distance_valid;
    logic [13:0] distance_cm;
    logic [1:0]  phase;

    modport source (output valid, output trigger, output segments, output digit_select,
                    output distance_valid, output distance_cm, output phase,
                    input ready);
    modport sink   (input valid, input trigger, input segments, input digit_select,
                    input distance_valid, input distance_cm, input phase,
                    output ready);
endinterface

@@ design/ultrasonic_ranging_seven_segment.sv @@
// The result of an accepted sample transaction is registered and offered in the next cycle.
// Throughput: one per cycle until result.ready stalls; output register refills as it drains.
// Distance is tracked tick by tick as a running quotient and BCD value, so the fall of
// echo only latches it and needs no divider.
// Reset (rst_n low, asynchronous): phase trigger, all counters and digits zero,
// registers at 100, 50100 and 100 ticks, no result held.
module ultrasonic_ranging_seven_segment
    import urss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    urss_sample_if.sink          sample,
    urss_result_if.source        result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [TRIG_W-1:0]  trigger_ticks_reg;
    logic [HOLD_W-1:0]  hold_ticks_reg;
    logic [DTICK_W-1:0] digit_ticks_reg;

    logic [1:0]             phase_reg, phase_next;
    logic [HOLD_W-1:0]      phase_timer_reg, phase_timer_next;
    logic [COUNT_WIDTH-1:0] echo_count_reg, echo_count_next;
    logic [REM_W-1:0]       run_rem_reg, run_rem_next;
    logic [DIST_W-1:0]      run_q_reg, run_q_next;
    bcd_word_t              run_bcd_reg, run_bcd_next;
    bcd_word_t              digit_store_reg, digit_store_next;
    logic [DIST_W-1:0]      distance_reg, distance_next;
    logic [DIGIT_IDX_W-1:0] digit_index_reg, digit_index_next;
    logic [DTICK_W-1:0]     digit_timer_reg, digit_timer_next;

    logic              out_valid_reg;
    logic              trigger_reg, trigger_next;
    logic [6:0]        segments_reg, segments_next;
    logic [SEL_W-1:0]  digit_select_reg, digit_select_next;
    logic              distance_valid_reg, distance_valid_next;
    logic [DIST_W-1:0] distance_cm_reg;
    logic [1:0]        phase_out_reg;

    logic accept;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        logic [HOLD_W:0]    timer_inc;
        logic [DTICK_W:0]   dtimer_inc;
        logic [REM_W:0]     rem_sum;
        logic               carry;

        timer_inc  = {1'b0, phase_timer_reg} + (HOLD_W+1)'(1);
        dtimer_inc = {1'b0, digit_timer_reg} + (DTICK_W+1)'(1);
        rem_sum    = {1'b0, run_rem_reg} + (REM_W+1)'(ECHO_NUM);
        carry      = 1'b0;

        phase_next          = phase_reg;
        phase_timer_next    = phase_timer_reg;
        echo_count_next     = echo_count_reg;
        run_rem_next        = run_rem_reg;
        run_q_next          = run_q_reg;
        run_bcd_next        = run_bcd_reg;
        digit_store_next    = digit_store_reg;
        distance_next       = distance_reg;
        distance_valid_next = 1'b0;

        unique case (phase_reg)
            PH_TRIG:
            begin
                if (timer_inc >= {{(HOLD_W+1-TRIG_W){1'b0}}, trigger_ticks_reg})
                begin
                    phase_next       = PH_WAIT;
                    phase_timer_next = '0;
                    echo_count_next  = '0;
                end
                else
                begin
                    phase_timer_next = timer_inc[HOLD_W-1:0];
                end
            end
            PH_WAIT:
            begin
                if (sample.echo)
                begin
                    phase_next      = PH_MEAS;
                    echo_count_next = COUNT_WIDTH'(1);
                    run_rem_next    = REM_W'(ECHO_NUM);
                    run_q_next      = '0;
                    run_bcd_next    = '0;
                end
            end
            PH_MEAS:
            begin
                if (sample.echo)
                begin
                    if (echo_count_reg != COUNT_MAX)
                    begin
                        echo_count_next = echo_count_reg + COUNT_WIDTH'(1);
                        if (rem_sum >= (REM_W+1)'(ECHO_DEN))
                        begin
                            run_rem_next = REM_W'(rem_sum - (REM_W+1)'(ECHO_DEN));
                            if (run_q_reg != DIST_W'(DIST_MAX))
                            begin
                                run_q_next = run_q_reg + DIST_W'(1);
                                carry      = 1'b1;
                                for (int i = 0; i < NUM_DIGITS; i++)
                                begin
                                    if (carry)
                                    begin
                                        if (run_bcd_reg[i] == 4'd9)
                                        begin
                                            run_bcd_next[i] = 4'd0;
                                        end
                                        else
                                        begin
                                            run_bcd_next[i] = run_bcd_reg[i] + 4'd1;
                                            carry           = 1'b0;
                                        end
                                    end
                                end
                            end
                        end
                        else
                        begin
                            run_rem_next = rem_sum[REM_W-1:0];
                        end
                    end
                end
                else
                begin
                    distance_next       = run_q_reg;
                    digit_store_next    = run_bcd_reg;
                    distance_valid_next = 1'b1;
                    phase_timer_next    = '0;
                    phase_next          = (hold_ticks_reg == '0) ? PH_TRIG : PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                if (timer_inc >= {1'b0, hold_ticks_reg})
                begin
                    phase_next       = PH_TRIG;
                    phase_timer_next = '0;
                end
                else
                begin
                    phase_timer_next = timer_inc[HOLD_W-1:0];
                end
            end
            default:
            begin
                phase_next = PH_TRIG;
            end
        endcase

        if (dtimer_inc >= {1'b0, digit_ticks_reg})
        begin
            digit_timer_next = '0;
            if (digit_index_reg == DIGIT_IDX_W'(NUM_DIGITS - 1))
            begin
                digit_index_next = '0;
            end
            else
            begin
                digit_index_next = digit_index_reg + DIGIT_IDX_W'(1);
            end
        end
        else
        begin
            digit_timer_next = dtimer_inc[DTICK_W-1:0];
            digit_index_next = digit_index_reg;
        end

        trigger_next  = (phase_reg == PH_TRIG);
        segments_next = seg_pattern(digit_store_reg[digit_index_reg]);
        for (int i = 0; i < SEL_W; i++)
        begin
            digit_select_next[i] = (32'(digit_index_reg) == i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIG_RESET;
            hold_ticks_reg    <= HOLD_RESET;
            digit_ticks_reg   <= DTICK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data[TRIG_W-1:0];
                CFG_HOLD_TICKS:    hold_ticks_reg    <= cfg_data[HOLD_W-1:0];
                CFG_DIGIT_TICKS:   digit_ticks_reg   <= cfg_data[DTICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TRIG;
            phase_timer_reg <= '0;
            echo_count_reg  <= '0;
            run_rem_reg     <= '0;
            run_q_reg       <= '0;
            run_bcd_reg     <= '0;
            digit_store_reg <= '0;
            distance_reg    <= '0;
            digit_index_reg <= '0;
            digit_timer_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            phase_timer_reg <= phase_timer_next;
            echo_count_reg  <= echo_count_next;
            run_rem_reg     <= run_rem_next;
            run_q_reg       <= run_q_next;
            run_bcd_reg     <= run_bcd_next;
            digit_store_reg <= digit_store_next;
            distance_reg    <= distance_next;
            digit_index_reg <= digit_index_next;
            digit_timer_reg <= digit_timer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trigger_reg        <= trigger_next;
            segments_reg       <= segments_next;
            digit_select_reg   <= digit_select_next;
            distance_valid_reg <= distance_valid_next;
            distance_cm_reg    <= distance_next;
            phase_out_reg      <= phase_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.trigger        = trigger_reg;
    assign result.segments       = segments_reg;
    assign result.digit_select   = digit_select_reg;
    assign result.distance_valid = distance_valid_reg;
    assign result.distance_cm    = distance_cm_reg;
    assign result.phase          = phase_out_reg;

endmodule

@@ tb/tb.sv @@
module tb;
    import urss_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    typedef struct packed {
        logic              trigger;
        logic [6:0]        segments;
        logic [SEL_W-1:0]  digit_select;
        logic              distance_valid;
        logic [DIST_W-1:0] distance_cm;
        logic [1:0]        phase;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    urss_sample_if sample_ch();
    urss_result_if result_ch();

    ultrasonic_ranging_seven_segment dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #6 clk = ~clk;

    logic [6:0] glyph [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                               7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

    // ranging state mirrored tick by tick
    logic [TRIG_W-1:0]      trig_len;
    logic [HOLD_W-1:0]      hold_len;
    logic [DTICK_W-1:0]     slot_len;
    logic [1:0]             stage;
    logic [HOLD_W-1:0]      stage_timer;
    logic [COUNT_WIDTH-1:0] pulse_len;
    bcd_t                   shown [NUM_DIGITS];
    logic [DIST_W-1:0]      range_cm;
    logic [DIGIT_IDX_W-1:0] scan_pos;
    logic [DTICK_W-1:0]     scan_timer;

    logic     echo_backlog [$];
    reading_t due_readings [$];
    reading_t want;
    reading_t got;

    int ticks_outstanding = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int ticks_checked = 0;
    int latches = 0;
    int saturated = 0;
    int reg_writes = 0;
    int cycles = 0;

    function automatic void reset_ranger();
        int i;
        trig_len    = TRIG_RESET;
        hold_len    = HOLD_RESET;
        slot_len    = DTICK_RESET;
        stage       = PH_TRIG;
        stage_timer = '0;
        pulse_len   = '0;
        for (i = 0; i < NUM_DIGITS; i++)
            shown[i] = '0;
        range_cm    = '0;
        scan_pos    = '0;
        scan_timer  = '0;
    endfunction

    function automatic void range_tick(input logic echo_level);
        reading_t    r;
        int unsigned quotient;
        int unsigned rest;
        int          i;
        r.trigger        = (stage == PH_TRIG);
        r.segments       = glyph[shown[scan_pos]];
        r.digit_select   = SEL_W'(1) << scan_pos;
        r.distance_valid = 1'b0;
        r.phase          = stage;
        case (stage)
            PH_TRIG:
                if (32'(stage_timer) + 32'd1 >= 32'(trig_len)) begin
                    stage       = PH_WAIT;
                    stage_timer = '0;
                    pulse_len   = '0;
                end else begin
                    stage_timer = stage_timer + 1'b1;
                end
            PH_WAIT:
                if (echo_level) begin
                    pulse_len = COUNT_WIDTH'(1);
                    stage     = PH_MEAS;
                end
            PH_MEAS:
                if (echo_level) begin
                    if (pulse_len != '1)
                        pulse_len = pulse_len + 1'b1;
                end else begin
                    quotient = (32'(pulse_len) * ECHO_NUM) / ECHO_DEN;
                    if (quotient > DIST_MAX) begin
                        quotient = DIST_MAX;
                        saturated++;
                    end
                    range_cm = DIST_W'(quotient);
                    rest = quotient;
                    for (i = 0; i < NUM_DIGITS; i++) begin
                        shown[i] = bcd_t'(rest % 10);
                        rest = rest / 10;
                    end
                    r.distance_valid = 1'b1;
                    latches++;
                    stage_timer = '0;
                    stage = (hold_len == '0) ? PH_TRIG : PH_HOLD;
                end
            default:
                if (32'(stage_timer) + 32'd1 >= 32'(hold_len)) begin
                    stage       = PH_TRIG;
                    stage_timer = '0;
                end else begin
                    stage_timer = stage_timer + 1'b1;
                end
        endcase
        if (32'(scan_timer) + 32'd1 >= 32'(slot_len)) begin
            scan_timer = '0;
            scan_pos   = DIGIT_IDX_W'((int'(scan_pos) + 1) % NUM_DIGITS);
        end else begin
            scan_timer = scan_timer + 1'b1;
        end
        r.distance_cm = range_cm;
        due_readings.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sample_ch.valid <= 1'b0;
            sample_ch.echo  <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready)
                range_tick(sample_ch.echo);
            if (!sample_ch.valid || sample_ch.ready) begin
                if (echo_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.echo  <= echo_backlog.pop_front();
                end else begin
                    sample_ch.valid <= 1'b0;
                    sample_ch.echo  <= 1'($urandom_range(1, 0));
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                ticks_outstanding--;
                ticks_checked++;
                got.trigger        = result_ch.trigger;
                got.segments       = result_ch.segments;
                got.digit_select   = result_ch.digit_select;
                got.distance_valid = result_ch.distance_valid;
                got.distance_cm    = result_ch.distance_cm;
                got.phase          = result_ch.phase;
                if (due_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: trig=%0b seg=%h sel=%b dv=%0b cm=%0d ph=%0d",
                                 got.trigger, got.segments, got.digit_select,
                                 got.distance_valid, got.distance_cm, got.phase);
                end else begin
                    want = due_readings.pop_front();
                    if (got.trigger !== want.trigger || got.segments !== want.segments
                        || got.digit_select !== want.digit_select
                        || got.distance_valid !== want.distance_valid
                        || got.distance_cm !== want.distance_cm
                        || got.phase !== want.phase) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("tick %0d expected trig=%0b seg=%h sel=%b dv=%0b cm=%0d ph=%0d",
                                     ticks_checked, want.trigger, want.segments,
                                     want.digit_select, want.distance_valid,
                                     want.distance_cm, want.phase);
                            $display("tick %0d actual   trig=%0b seg=%h sel=%b dv=%0b cm=%0d ph=%0d",
                                     ticks_checked, got.trigger, got.segments,
                                     got.digit_select, got.distance_valid,
                                     got.distance_cm, got.phase);
                        end
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_TRIGGER_TICKS: trig_len = data[TRIG_W-1:0];
            CFG_HOLD_TICKS:    hold_len = data[HOLD_W-1:0];
            CFG_DIGIT_TICKS:   slot_len = data[DTICK_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic push_ticks(input logic level, input int n);
        repeat (n) echo_backlog.push_back(level);
        ticks_outstanding += n;
    endtask

    task automatic settle();
        while (ticks_outstanding > 0)
            @(posedge clk);
    endtask

    task automatic shuffle_settings();
        logic [TRIG_W-1:0]  trig;
        logic [DTICK_W-1:0] slot;
        trig = ($urandom_range(9, 0) == 0) ? '0 : TRIG_W'($urandom_range(6, 1));
        slot = ($urandom_range(9, 0) == 0) ? '0 : DTICK_W'($urandom_range(5, 1));
        set_reg(CFG_TRIGGER_TICKS, {8'($urandom_range(255, 0)), trig});
        set_reg(CFG_HOLD_TICKS, CFG_W'($urandom_range(8, 0)));
        set_reg(CFG_DIGIT_TICKS, {8'($urandom_range(255, 0)), slot});
    endtask

    // mostly whole pulses timed to land in the wait phase, some raw noise
    task automatic random_batch(input int target);
        int produced;
        int gap;
        int len;
        int room;
        int trig_eff;
        produced = 0;
        trig_eff = (trig_len == '0) ? 1 : int'(trig_len);
        while (produced < target) begin
            if ($urandom_range(9, 0) < 2) begin
                len = $urandom_range(12, 1);
                repeat (len) push_ticks(1'($urandom_range(1, 0)), 1);
                produced += len;
            end else begin
                gap = trig_eff + int'(hold_len) + $urandom_range(4, 0);
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(400, 41)
                                                   : $urandom_range(40, 1);
                room = target - produced - gap;
                if (len > room)
                    len = (room > 0) ? room : 1;
                push_ticks(1'b0, gap);
                push_ticks(1'b1, len);
                produced += gap + len;
            end
        end
    endtask

    initial begin
        int mode;
        int batch;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_TRIGGER_TICKS;
        cfg_data        = '0;
        reset_ranger();
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // reset settings, still in the trigger phase
        push_ticks(1'b1, 1);
        push_ticks(1'b0, 1);
        push_ticks(1'b1, 1);
        push_ticks(1'b0, 1);
        settle();

        // zero lengths, skipped hold, ignored index
        set_reg(CFG_TRIGGER_TICKS, '0);
        set_reg(CFG_HOLD_TICKS, '0);
        set_reg(CFG_DIGIT_TICKS, '0);
        set_reg(CFG_UNUSED, '1);
        push_ticks(1'b0, 1);
        push_ticks(1'b1, 1);
        push_ticks(1'b0, 2);
        push_ticks(1'b1, 7);
        push_ticks(1'b0, 1);
        settle();

        // over-wide writes masked, hold at its ceiling
        set_reg(CFG_TRIGGER_TICKS, 24'hFF0002);
        set_reg(CFG_HOLD_TICKS, '1);
        set_reg(CFG_DIGIT_TICKS, 24'hFF0001);
        push_ticks(1'b0, 3);
        push_ticks(1'b1, 6);
        push_ticks(1'b0, 1);
        push_ticks(1'b1, 1);
        push_ticks(1'b0, 1);
        settle();

        // trigger and digit slot at their ceilings
        set_reg(CFG_TRIGGER_TICKS, CFG_W'(16'hFFFF));
        set_reg(CFG_DIGIT_TICKS, CFG_W'(16'hFFFF));
        set_reg(CFG_HOLD_TICKS, CFG_W'(2));
        push_ticks(1'b0, 1);
        push_ticks(1'b1, 1);
        push_ticks(1'b0, 1);
        push_ticks(1'b1, 1);
        settle();

        // long echo: two-digit value through many decimal carries
        set_reg(CFG_TRIGGER_TICKS, CFG_W'(1));
        set_reg(CFG_HOLD_TICKS, '0);
        set_reg(CFG_DIGIT_TICKS, CFG_W'(1));
        push_ticks(1'b0, 3);
        push_ticks(1'b1, 350);
        push_ticks(1'b0, 3);
        settle();

        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (batch = 0; batch < 4; batch++) begin
                shuffle_settings();
                random_batch(32);
                settle();
            end
        end

        repeat (4) @(posedge clk);
        $display("Checked %0d ticks, %0d distance latches (%0d saturated), %0d register writes",
                 ticks_checked, latches, saturated, reg_writes);
        $display("Handshake mixes: free running, sender gaps, receiver stalls, light both ways");
        if (mismatches == 0 && due_readings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
